// ===== rtl/azs_pkg.sv =====
package azs_pkg;

	// Defaults for the top-level parameters
	localparam int ADDR_WIDTH_DEF = 32;
	localparam int MAX_STORES_DEF = 8;

	// Field widths
	localparam int OFF_W   = 32;
	localparam int SIZE_W  = 32;
	localparam int ALIGN_W = 13;
	localparam int DATA_W  = 80;

	// Widest single store in bytes
	localparam int WIDEST_STORE = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COUNT,
		ST_EMIT,
		ST_BULK_CHK,
		ST_BULK_DIV,
		ST_BULK_OUT
	} azs_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;      // capture a new request
		logic step;      // take one store off the region
		logic rewind;    // restart the walk from the start offset
		logic bulk_init; // start the alignment reduction
		logic div_init;  // start a remainder pass for the current alignment
		logic div_step;  // one remainder bit
		logic halve;     // halve the candidate alignment
		logic sel_bulk;  // present the bulk result
	} azs_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic in_zero;    // incoming byte count is zero
		logic step_last;  // current store finishes the region
		logic cnt_last;   // store budget is used up by the current store
		logic a_le_one;   // candidate alignment is one or less
		logic div_done;   // last remainder bit is being taken
		logic rem_zero;   // remainder after this bit is zero
	} azs_status_t;

endpackage

// ===== rtl/aligned_zero_store_splitter.sv =====
// After the accepting edge the stores of the region are counted (at most MAX_STORES), then
// rewound and given as one store result per cycle while m_axis_tready is high. A bulk
// clear is used when MAX_STORES stores do not cover the region; it tests each candidate
// alignment above one by bit-serial remainder, halving until it divides or reaches one.
// One request is in flight; the next is taken the cycle after the last result.
// arst_n clears the controller asynchronously; no clearing pass is needed.
module aligned_zero_store_splitter
	import azs_pkg::*;
#(
	parameter int ADDR_WIDTH = ADDR_WIDTH_DEF,
	parameter int MAX_STORES = MAX_STORES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// start_offset[31:0], byte_count[63:32], align_bytes[76:64], zero pad
	input  logic [DATA_W-1:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// out_offset[31:0], out_size[63:32], out_align[76:64], zero pad
	output logic [DATA_W-1:0] m_axis_tdata,
	// is_bulk[0]
	output logic              m_axis_tuser,
	// last_of_run
	output logic              m_axis_tlast
);

	azs_cmd_t    cmd;
	azs_status_t status;
	logic        in_fire;

	// Accept a request on the input handshake
	assign in_fire = s_axis_tvalid && s_axis_tready;

	azs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.out_ready (m_axis_tready),
		.status    (status),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.cmd       (cmd)
	);

	azs_datapath #(
		.ADDR_WIDTH (ADDR_WIDTH),
		.MAX_STORES (MAX_STORES)
	) u_datapath (
		.clk      (clk),
		.in_data  (s_axis_tdata),
		.cmd      (cmd),
		.status   (status),
		.out_data (m_axis_tdata),
		.out_bulk (m_axis_tuser),
		.out_last (m_axis_tlast)
	);

endmodule

// ===== rtl/azs_ctrl.sv =====
module azs_ctrl
	import azs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_fire,
	input  logic        out_ready,
	input  azs_status_t status,
	output logic        in_ready,
	output logic        out_valid,
	output azs_cmd_t    cmd
);

	azs_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && !status.in_zero) begin
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				if (status.step_last) begin
					state_d = ST_EMIT;
				end else if (status.cnt_last) begin
					state_d = ST_BULK_CHK;
				end
			end
			ST_EMIT: begin
				if (out_ready && status.step_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_BULK_CHK: begin
				state_d = status.a_le_one ? ST_BULK_OUT : ST_BULK_DIV;
			end
			ST_BULK_DIV: begin
				if (status.div_done) begin
					state_d = status.rem_zero ? ST_BULK_OUT : ST_BULK_CHK;
				end
			end
			ST_BULK_OUT: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_fire;
			end
			ST_COUNT: begin
				cmd.step      = 1'b1;
				cmd.rewind    = status.step_last;
				cmd.bulk_init = !status.step_last && status.cnt_last;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				cmd.step  = out_ready;
			end
			ST_BULK_CHK: begin
				cmd.div_init = !status.a_le_one;
				cmd.sel_bulk = 1'b1;
			end
			ST_BULK_DIV: begin
				cmd.div_step = 1'b1;
				cmd.halve    = status.div_done && !status.rem_zero;
				cmd.sel_bulk = 1'b1;
			end
			ST_BULK_OUT: begin
				out_valid    = 1'b1;
				cmd.sel_bulk = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/azs_datapath.sv =====
module azs_datapath
	import azs_pkg::*;
#(
	parameter int ADDR_WIDTH = ADDR_WIDTH_DEF,
	parameter int MAX_STORES = MAX_STORES_DEF
) (
	input  logic               clk,
	input  logic [DATA_W-1:0]  in_data,
	input  azs_cmd_t           cmd,
	output azs_status_t        status,
	output logic [DATA_W-1:0]  out_data,
	output logic               out_bulk,
	output logic               out_last
);

	// Offsets wrap at the address space, and only the low field bits are seen
	localparam int AW   = (ADDR_WIDTH < OFF_W) ? ADDR_WIDTH : OFF_W;
	localparam int CW   = $clog2(MAX_STORES + 1);
	localparam int BW   = $clog2(AW);
	localparam int PADW = DATA_W - OFF_W - SIZE_W - ALIGN_W;

	logic [AW-1:0]      off_q;
	logic [SIZE_W-1:0]  bytes_q;
	logic [ALIGN_W-1:0] align_q;
	logic [AW-1:0]      at_q;
	logic [SIZE_W-1:0]  left_q;
	logic [CW-1:0]      cnt_q;
	logic [ALIGN_W-1:0] a_q;
	logic [ALIGN_W-1:0] rem_q;
	logic [BW-1:0]      bit_q;

	logic [ALIGN_W-1:0] in_align;
	logic [3:0]         w;
	logic [ALIGN_W:0]   rem_sh;
	logic [ALIGN_W-1:0] rem_next;

	// Treat a zero alignment as one
	assign in_align = (in_data[OFF_W+SIZE_W +: ALIGN_W] == '0) ? ALIGN_W'(1)
	                  : in_data[OFF_W+SIZE_W +: ALIGN_W];

	// Pick the widest store that fits the bytes left, alignment and offset
	always_comb begin
		if (left_q >= SIZE_W'(WIDEST_STORE) && align_q >= ALIGN_W'(WIDEST_STORE)
		    && at_q[2:0] == 3'd0) begin
			w = 4'd8;
		end else if (left_q >= SIZE_W'(4) && align_q >= ALIGN_W'(4) && at_q[1:0] == 2'd0) begin
			w = 4'd4;
		end else if (left_q >= SIZE_W'(2) && align_q >= ALIGN_W'(2) && !at_q[0]) begin
			w = 4'd2;
		end else begin
			w = 4'd1;
		end
	end

	// One restoring remainder bit of offset modulo the candidate alignment
	assign rem_sh   = {rem_q, off_q[bit_q]};
	assign rem_next = (rem_sh >= {1'b0, a_q}) ? ALIGN_W'(rem_sh - {1'b0, a_q})
	                  : rem_sh[ALIGN_W-1:0];

	// Request capture, region walk and alignment reduction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			off_q   <= in_data[AW-1:0];
			bytes_q <= in_data[OFF_W +: SIZE_W];
			align_q <= in_align;
			at_q    <= in_data[AW-1:0];
			left_q  <= in_data[OFF_W +: SIZE_W];
			cnt_q   <= '0;
		end else if (cmd.rewind) begin
			at_q   <= off_q;
			left_q <= bytes_q;
		end else if (cmd.step) begin
			at_q   <= at_q + AW'(w);
			left_q <= left_q - SIZE_W'(w);
			cnt_q  <= cnt_q + CW'(1);
		end

		if (cmd.bulk_init) begin
			a_q <= align_q;
		end else if (cmd.halve) begin
			a_q <= a_q >> 1;
		end

		if (cmd.div_init) begin
			rem_q <= '0;
			bit_q <= BW'(AW - 1);
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			bit_q <= bit_q - BW'(1);
		end
	end

	// Status back to the controller
	always_comb begin
		status.in_zero   = (in_data[OFF_W +: SIZE_W] == '0);
		status.step_last = (left_q == SIZE_W'(w));
		status.cnt_last  = (cnt_q == CW'(MAX_STORES - 1));
		status.a_le_one  = (a_q <= ALIGN_W'(1));
		status.div_done  = (bit_q == '0);
		status.rem_zero  = (rem_next == '0);
	end

	// Result fields
	always_comb begin
		if (cmd.sel_bulk) begin
			out_data = {{PADW{1'b0}}, a_q, bytes_q, OFF_W'(off_q)};
			out_last = 1'b1;
		end else begin
			out_data = {{PADW{1'b0}}, ALIGN_W'(w), SIZE_W'(w), OFF_W'(at_q)};
			out_last = status.step_last;
		end
		out_bulk = cmd.sel_bulk;
	end

endmodule
